// ----- hw/rtl/stun_message_parser_core_defines.svh -----
// Assertion macros for the STUN message parser RTL.
`ifndef STUN_MESSAGE_PARSER_CORE_DEFINES_SVH
`define STUN_MESSAGE_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define STUNMP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define STUNMP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/stunmp_pkg.sv -----
// Types, constants and the byte-wide CRC-32 step of the STUN message parser.
package stunmp_pkg;

	localparam logic [31:0] MAGIC_COOKIE  = 32'h2112A442;
	localparam logic [15:0] T_USERNAME    = 16'h0006;
	localparam logic [15:0] T_INTEGRITY   = 16'h0008;
	localparam logic [15:0] T_FINGERPRINT = 16'h8028;
	localparam logic [31:0] FP_XOR        = 32'h5354554E;
	localparam logic [31:0] CRC_POLY      = 32'hEDB88320;
	localparam logic [31:0] ALL_ONES      = 32'hFFFFFFFF;
	localparam logic [16:0] HDR_BYTES     = 17'd20;
	localparam logic [16:0] COUNT_MAX     = 17'd65556;

	// Result queue geometry.
	localparam int QUEUE_AW    = 2;
	localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

	localparam logic RK_USERNAME = 1'b0;
	localparam logic RK_VERDICT  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_TOO_SHORT   = 3'd1,
		ST_BAD_MAGIC   = 3'd2,
		ST_TRUNCATED   = 3'd3,
		ST_FP_MISMATCH = 3'd4
	} status_t;

	// One result beat.
	typedef struct packed {
		logic        result_kind;
		logic        username_start;
		logic [7:0]  username_byte;
		status_t     status;
		logic        valid_res;
		logic [15:0] msg_type;
		logic [31:0] txid_high;
		logic [63:0] txid_low;
		logic        has_integrity;
		logic        has_fp;
		logic [15:0] username_length;
		logic        run_last;
	} res_t;

	// Fill state of the result queue.
	typedef struct packed {
		logic [QUEUE_AW:0] count;
		logic              not_empty;
		logic              room_two;
	} queue_stat_t;

	// Reflected CRC-32 over one byte.
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
		logic [31:0] c;
		c = crc_in ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/stunmp_res_queue.sv -----
// Small result queue that takes up to two result beats per cycle and hands out one.
module stunmp_res_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [1:0]             push_cnt,
	input  stunmp_pkg::res_t       push_a,
	input  stunmp_pkg::res_t       push_b,
	input  logic                   pop,
	output stunmp_pkg::res_t       head,
	output stunmp_pkg::queue_stat_t stat
);

	localparam int AW = stunmp_pkg::QUEUE_AW;
	localparam int DEPTH = stunmp_pkg::QUEUE_DEPTH;

	stunmp_pkg::res_t entry_q [DEPTH];
	logic [AW-1:0] wptr_q;
	logic [AW-1:0] rptr_q;
	logic [AW:0]   count_q;
	logic [AW-1:0] wptr_nxt;

	assign wptr_nxt = AW'(wptr_q + 1'b1);

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= AW'(wptr_q + push_cnt);
			if (pop) begin
				rptr_q <= AW'(rptr_q + 1'b1);
			end
			count_q <= (AW+1)'(count_q + {{(AW-1){1'b0}}, push_cnt} - {{AW{1'b0}}, pop});
		end
	end

	// Entry storage; the payload needs no reset.
	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			entry_q[wptr_q] <= push_a;
		end
		if (push_cnt == 2'd2) begin
			entry_q[wptr_nxt] <= push_b;
		end
	end

	assign head           = entry_q[rptr_q];
	assign stat.count     = count_q;
	assign stat.not_empty = (count_q != '0);
	assign stat.room_two  = (count_q <= (AW+1)'(DEPTH - 2));

endmodule

// ----- hw/rtl/stun_message_parser_core.sv -----
// STUN parser: one packet byte per cycle in while pkt_ready is high; results are registered in a result queue.
// The header capture, attribute walk and table-free CRC step all sit between the state
// registers and a four-entry result queue.
// The last byte of a packet queues up to two results, so pkt_ready drops when fewer than two
// queue entries are free. Asynchronous reset clears the parser state and empties the queue;
// the parser also returns to its reset state after every final byte.
`include "stun_message_parser_core_defines.svh"

module stun_message_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pkt_valid,
	output logic        pkt_ready,
	input  logic [7:0]  packet_byte,
	input  logic        end_of_packet,
	output logic        res_valid,
	input  logic        res_ready,
	output logic        result_kind,
	output logic        username_start,
	output logic [7:0]  username_byte,
	output logic [2:0]  status,
	output logic        valid_res,
	output logic [15:0] msg_type,
	output logic [31:0] txid_high,
	output logic [63:0] txid_low,
	output logic        has_integrity,
	output logic        has_fp,
	output logic [15:0] username_length,
	output logic        run_last
);

	// Parser state.
	logic [16:0] byte_count_q, byte_count_nx;
	logic [15:0] header_type_q, header_type_nx;
	logic [15:0] body_len_q, body_len_nx;
	logic [31:0] cookie_q, cookie_nx;
	logic [31:0] tid_upper_q, tid_upper_nx;
	logic [63:0] tid_lower_q, tid_lower_nx;
	logic [31:0] crc_q, crc_nx;
	logic [31:0] crc_attr_q, crc_attr_nx;
	logic [15:0] attr_kind_q, attr_kind_nx;
	logic [15:0] attr_length_q, attr_length_nx;
	logic [16:0] next_attr_pos_q, next_attr_pos_nx;
	logic [31:0] fp_received_q, fp_received_nx;
	logic        walk_stopped_q, walk_stopped_nx;
	logic        fp_failed_q, fp_failed_nx;
	logic [1:0]  seen_flags_q, seen_flags_nx;
	logic [15:0] user_len_q, user_len_nx;

	// Step decode.
	logic        acc;
	logic [16:0] end_pos;
	logic        in_walk;
	logic [16:0] hdr_off;
	logic [17:0] val_start_new;
	logic        hdr_fits;
	logic [15:0] len_full;
	logic [16:0] pad_full;
	logic        len_overrun;
	logic [16:0] pad_cur;
	logic [16:0] val_start;
	logic [16:0] val_off;
	logic        in_value;
	logic        is_user;
	logic        is_fp4;
	logic [31:0] fp_shift;
	logic        emit_user;
	logic [1:0]  push_cnt;

	stunmp_pkg::res_t        user_res;
	stunmp_pkg::res_t        verdict_res;
	stunmp_pkg::res_t        push_a;
	stunmp_pkg::res_t        head;
	stunmp_pkg::queue_stat_t q_stat;

	assign acc = pkt_valid & pkt_ready;

	// Positions within the packet.
	assign end_pos       = stunmp_pkg::HDR_BYTES + {1'b0, body_len_q};
	assign in_walk       = (byte_count_q >= stunmp_pkg::HDR_BYTES)
		&& (cookie_q == stunmp_pkg::MAGIC_COOKIE) && !walk_stopped_q
		&& (byte_count_q < end_pos);
	assign hdr_off       = byte_count_q - next_attr_pos_q;
	assign val_start_new = {1'b0, next_attr_pos_q} + 18'd4;
	assign hdr_fits      = (val_start_new <= {1'b0, end_pos}) && (hdr_off < 17'd4);
	assign len_full      = {attr_length_q[15:8], packet_byte};
	assign pad_full      = ({1'b0, len_full} + 17'd3) & ~17'd3;
	assign len_overrun   = (val_start_new + {2'b0, len_full}) > {1'b0, end_pos};
	assign pad_cur       = ({1'b0, attr_length_q} + 17'd3) & ~17'd3;
	assign val_start     = next_attr_pos_q - pad_cur;
	assign val_off       = byte_count_q - val_start;
	assign in_value      = (byte_count_q >= val_start)
		&& ({1'b0, byte_count_q} < ({1'b0, val_start} + {2'b0, attr_length_q}));
	assign is_user       = (attr_kind_q == stunmp_pkg::T_USERNAME);
	assign is_fp4        = (attr_kind_q == stunmp_pkg::T_FINGERPRINT) && (attr_length_q == 16'd4);
	assign fp_shift      = {fp_received_q[23:0], packet_byte};

	// Next state of the parser for the byte in flight.
	always_comb begin
		byte_count_nx    = byte_count_q;
		header_type_nx   = header_type_q;
		body_len_nx      = body_len_q;
		cookie_nx        = cookie_q;
		tid_upper_nx     = tid_upper_q;
		tid_lower_nx     = tid_lower_q;
		crc_attr_nx      = crc_attr_q;
		attr_kind_nx     = attr_kind_q;
		attr_length_nx   = attr_length_q;
		next_attr_pos_nx = next_attr_pos_q;
		fp_received_nx   = fp_received_q;
		walk_stopped_nx  = walk_stopped_q;
		fp_failed_nx     = fp_failed_q;
		seen_flags_nx    = seen_flags_q;
		user_len_nx      = user_len_q;
		emit_user        = 1'b0;

		if (byte_count_q < 17'd2) begin
			header_type_nx = {header_type_q[7:0], packet_byte};
		end else if (byte_count_q < 17'd4) begin
			body_len_nx = {body_len_q[7:0], packet_byte};
		end else if (byte_count_q < 17'd8) begin
			cookie_nx = {cookie_q[23:0], packet_byte};
		end else if (byte_count_q < 17'd12) begin
			tid_upper_nx = {tid_upper_q[23:0], packet_byte};
		end else if (byte_count_q < stunmp_pkg::HDR_BYTES) begin
			tid_lower_nx = {tid_lower_q[55:0], packet_byte};
		end else if (in_walk) begin
			if (byte_count_q >= next_attr_pos_q) begin
				// Attribute header bytes.
				if (hdr_fits) begin
					case (hdr_off[1:0])
						2'd0: begin
							crc_attr_nx  = crc_q;
							attr_kind_nx = {packet_byte, 8'h00};
						end
						2'd1: begin
							attr_kind_nx = {attr_kind_q[15:8], packet_byte};
						end
						2'd2: begin
							attr_length_nx = {packet_byte, 8'h00};
						end
						default: begin
							attr_length_nx = len_full;
							if (len_overrun) begin
								walk_stopped_nx = 1'b1;
							end else begin
								if (attr_kind_q == stunmp_pkg::T_USERNAME) begin
									user_len_nx = len_full;
								end else if (attr_kind_q == stunmp_pkg::T_INTEGRITY) begin
									seen_flags_nx[0] = 1'b1;
								end else if (attr_kind_q == stunmp_pkg::T_FINGERPRINT
									&& len_full == 16'd4) begin
									seen_flags_nx[1] = 1'b1;
								end
								next_attr_pos_nx = 17'(val_start_new + {1'b0, pad_full});
							end
						end
					endcase
				end
			end else if (in_value) begin
				// Attribute value bytes.
				if (is_user) begin
					emit_user = 1'b1;
				end else if (is_fp4) begin
					fp_received_nx = fp_shift;
					if (val_off == 17'd3 && fp_shift != (crc_attr_q ^ stunmp_pkg::ALL_ONES
						^ stunmp_pkg::FP_XOR)) begin
						fp_failed_nx    = 1'b1;
						walk_stopped_nx = 1'b1;
					end
				end
			end
		end

		crc_nx        = stunmp_pkg::crc32_byte(crc_q, packet_byte);
		byte_count_nx = (byte_count_q >= stunmp_pkg::COUNT_MAX) ? stunmp_pkg::COUNT_MAX
			: 17'(byte_count_q + 17'd1);
	end

	// Username beat.
	always_comb begin
		user_res                = '0;
		user_res.result_kind    = stunmp_pkg::RK_USERNAME;
		user_res.username_start = (val_off == 17'd0);
		user_res.username_byte  = packet_byte;
		user_res.status         = stunmp_pkg::ST_OK;
		user_res.run_last       = !end_of_packet;
	end

	// Verdict beat, built from the state after this byte.
	always_comb begin
		verdict_res             = '0;
		verdict_res.result_kind = stunmp_pkg::RK_VERDICT;
		verdict_res.run_last    = 1'b1;
		verdict_res.status      = stunmp_pkg::ST_OK;
		if (byte_count_nx < stunmp_pkg::HDR_BYTES) begin
			verdict_res.status = stunmp_pkg::ST_TOO_SHORT;
		end else if (cookie_nx != stunmp_pkg::MAGIC_COOKIE) begin
			verdict_res.status   = stunmp_pkg::ST_BAD_MAGIC;
			verdict_res.msg_type = header_type_nx;
		end else begin
			verdict_res.msg_type  = header_type_nx;
			verdict_res.txid_high = tid_upper_nx;
			verdict_res.txid_low  = tid_lower_nx;
			if (byte_count_nx < end_pos) begin
				verdict_res.status = stunmp_pkg::ST_TRUNCATED;
			end else begin
				verdict_res.status          = fp_failed_nx ? stunmp_pkg::ST_FP_MISMATCH
					: stunmp_pkg::ST_OK;
				verdict_res.valid_res       = !fp_failed_nx;
				verdict_res.has_integrity   = seen_flags_nx[0];
				verdict_res.has_fp          = seen_flags_nx[1];
				verdict_res.username_length = user_len_nx;
			end
		end
	end

	// Queue push selection.
	always_comb begin
		push_a   = emit_user ? user_res : verdict_res;
		push_cnt = 2'd0;
		if (acc) begin
			push_cnt = {1'b0, emit_user} + {1'b0, end_of_packet};
		end
	end

	// Parser state registers; the final byte returns them to reset values.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			header_type_q   <= '0;
			body_len_q      <= '0;
			cookie_q        <= '0;
			tid_upper_q     <= '0;
			tid_lower_q     <= '0;
			crc_q           <= stunmp_pkg::ALL_ONES;
			crc_attr_q      <= '0;
			attr_kind_q     <= '0;
			attr_length_q   <= '0;
			next_attr_pos_q <= stunmp_pkg::HDR_BYTES;
			fp_received_q   <= '0;
			walk_stopped_q  <= 1'b0;
			fp_failed_q     <= 1'b0;
			seen_flags_q    <= '0;
			user_len_q      <= '0;
		end else if (acc) begin
			if (end_of_packet) begin
				byte_count_q    <= '0;
				header_type_q   <= '0;
				body_len_q      <= '0;
				cookie_q        <= '0;
				tid_upper_q     <= '0;
				tid_lower_q     <= '0;
				crc_q           <= stunmp_pkg::ALL_ONES;
				crc_attr_q      <= '0;
				attr_kind_q     <= '0;
				attr_length_q   <= '0;
				next_attr_pos_q <= stunmp_pkg::HDR_BYTES;
				fp_received_q   <= '0;
				walk_stopped_q  <= 1'b0;
				fp_failed_q     <= 1'b0;
				seen_flags_q    <= '0;
				user_len_q      <= '0;
			end else begin
				byte_count_q    <= byte_count_nx;
				header_type_q   <= header_type_nx;
				body_len_q      <= body_len_nx;
				cookie_q        <= cookie_nx;
				tid_upper_q     <= tid_upper_nx;
				tid_lower_q     <= tid_lower_nx;
				crc_q           <= crc_nx;
				crc_attr_q      <= crc_attr_nx;
				attr_kind_q     <= attr_kind_nx;
				attr_length_q   <= attr_length_nx;
				next_attr_pos_q <= next_attr_pos_nx;
				fp_received_q   <= fp_received_nx;
				walk_stopped_q  <= walk_stopped_nx;
				fp_failed_q     <= fp_failed_nx;
				seen_flags_q    <= seen_flags_nx;
				user_len_q      <= user_len_nx;
			end
		end
	end

	// Result queue between the parser and the output channel.
	stunmp_res_queue u_res_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (push_cnt),
		.push_a   (push_a),
		.push_b   (verdict_res),
		.pop      (res_valid & res_ready),
		.head     (head),
		.stat     (q_stat)
	);

	assign pkt_ready       = q_stat.room_two;
	assign res_valid       = q_stat.not_empty;
	assign result_kind     = head.result_kind;
	assign username_start  = head.username_start;
	assign username_byte   = head.username_byte;
	assign status          = head.status;
	assign valid_res       = head.valid_res;
	assign msg_type        = head.msg_type;
	assign txid_high       = head.txid_high;
	assign txid_low        = head.txid_low;
	assign has_integrity   = head.has_integrity;
	assign has_fp          = head.has_fp;
	assign username_length = head.username_length;
	assign run_last        = head.run_last;

	// Checks on the parser and queue.
	`STUNMP_ASSERT_NOW(a_queue_bound, 1'b1, q_stat.count <= (stunmp_pkg::QUEUE_AW+1)'(stunmp_pkg::QUEUE_DEPTH), "result queue overflow")
	`STUNMP_ASSERT_NEXT(a_packet_restart, acc && end_of_packet, byte_count_q == '0 && crc_q == stunmp_pkg::ALL_ONES, "parser not reset after final beat")
	`STUNMP_ASSERT_NOW(a_count_sat, 1'b1, byte_count_q <= stunmp_pkg::COUNT_MAX, "byte count past saturation")
	`STUNMP_ASSERT_NOW(a_fp_stops_walk, fp_failed_q, walk_stopped_q, "fingerprint mismatch without walk stop")

endmodule
